// ===== rtl/tgvrt_pkg.sv =====
package tgvrt_pkg;

  localparam logic [2:0] FN_ADDR_WR  = 3'd0;
  localparam logic [2:0] FN_ADDR_RD  = 3'd1;
  localparam logic [2:0] FN_DATA_WR  = 3'd2;
  localparam logic [2:0] FN_DATA_RD  = 3'd3;
  localparam logic [2:0] FN_KEY_STAT = 3'd4;
  localparam logic [2:0] FN_KEY_DATA = 3'd5;
  localparam logic [2:0] FN_INJECT   = 3'd6;
  localparam logic [2:0] FN_QUERY    = 3'd7;

  localparam logic [15:0] CTL_KEY_ON  = 16'h8100;
  localparam logic [15:0] CTL_KEY_OFF = 16'h7e00;
  localparam logic [15:0] CTL_RELEASE = 16'h1200;
  localparam logic [15:0] CTL_OFF     = 16'h0000;
  localparam logic [7:0]  NOTE_OFS_KEY   = 8'h24;
  localparam logic [7:0]  NOTE_OFS_PITCH = 8'd24;
  localparam logic [7:0]  DEFAULT_VEL    = 8'd200;
  localparam logic [7:0]  NOTE_MAX       = 8'd127;
  localparam int          ADDR_W         = 12;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] bus_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  active_voices;
    logic [7:0]  voice_note;
    logic [7:0]  voice_velocity;
    logic        voice_sounding;
    logic        voice_releasing;
    logic        key_overflow;
  } out_item_t;

endpackage

// ===== rtl/tgvrt_front.sv =====
module tgvrt_front
  import tgvrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  input  logic     pop,
  output logic     busy,
  output logic     q_valid,
  output in_item_t q_item
);
  // two-entry queue between bus side and execution
  in_item_t  q_mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/tgvrt_back.sv =====
module tgvrt_back
  import tgvrt_pkg::*;
#(
  parameter int VOICE_COUNT     = 64,
  parameter int PENDING_DEPTH   = 16,
  parameter int KEY_QUEUE_DEPTH = 16,
  parameter int REG_WORDS       = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      pop,
  output logic      out_strobe,
  output out_item_t out_item
);
  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int KW = (KEY_QUEUE_DEPTH > 1) ? $clog2(KEY_QUEUE_DEPTH) : 1;
  localparam int RW = $clog2(REG_WORDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_CLR  = 2'd2;

  logic [1:0] st_r;
  logic [RW-1:0] clr_r;
  in_item_t cur_r;

  logic [15:0] rf_mem [REG_WORDS];
  logic [15:0] rf_q_r;
  logic [15:0] pq_mem [PENDING_DEPTH];
  logic [15:0] kq_mem [KEY_QUEUE_DEPTH];
  logic [15:0] pq_q_r, kq_q_r;

  logic [ADDR_W-1:0] addr_r;
  logic [15:0] pitch_r [VOICE_COUNT];
  logic [7:0]  note_r  [VOICE_COUNT];
  logic [7:0]  vel_r   [VOICE_COUNT];
  logic [15:0] pitch_q_r;
  logic [7:0]  note_q_r, vel_q_r;
  logic [VOICE_COUNT-1:0] act_r, snd_r, rel_r;
  logic [6:0] acnt_r, acnt_nxt;

  logic [PW-1:0] ph_r, pt_r;
  logic [PW:0]   pc_r;
  logic [KW-1:0] kh_r, kt_r;
  logic [KW:0]   kc_r;

  logic [15:0] d;
  logic [5:0]  ch, fch, clr_ch;
  logic        ch_ok, fch_ok, vsel, grp0_wr, clr_ok;
  logic [7:0]  pn, pend_note;
  logic [6:0]  qch;
  logic        exec;
  logic [15:0] pend_w;
  out_item_t   res_nxt;

  always_comb begin
    d       = cur_r.bus_data;
    ch      = addr_r[5:0];
    ch_ok   = ({1'b0, ch} < 7'(VOICE_COUNT));
    vsel    = ch_ok && (addr_r[7:6] == 2'd0);
    grp0_wr = (cur_r.func == FN_DATA_WR) && vsel && (addr_r[11:8] == 4'd0);
    fch     = q_item.bus_data[5:0];
    fch_ok  = ({1'b0, fch} < 7'(VOICE_COUNT));
    pn      = pitch_q_r[15:8] + NOTE_OFS_PITCH;
    if (pn > NOTE_MAX) pn = NOTE_MAX;
    pend_note = 8'(kq_q_r[6:0]) + NOTE_OFS_KEY;
    qch     = {1'b0, d[5:0]};
    acnt_nxt = acnt_r;
    if (grp0_wr) begin
      if (d == CTL_KEY_ON) begin
        if (!act_r[ch]) acnt_nxt = acnt_r + 7'd1;
      end else if (d == CTL_KEY_OFF || d == CTL_RELEASE || d == CTL_OFF) begin
        if (act_r[ch] && acnt_r != '0) acnt_nxt = acnt_r - 7'd1;
      end
    end
  end

  // fetch: reads issued while item enters execute
  always_ff @(posedge clk) begin
    rf_q_r    <= rf_mem[addr_r[RW-1:0]];
    pq_q_r    <= pq_mem[pt_r];
    kq_q_r    <= kq_mem[kt_r];
    pitch_q_r <= pitch_r[ch_ok ? ch : '0];
    note_q_r  <= note_r[fch_ok ? fch : '0];
    vel_q_r   <= vel_r[fch_ok ? fch : '0];
  end

  assign pop = (st_r == ST_IDLE) && q_valid;
  assign exec = (st_r == ST_EXEC);
  assign pend_w = pq_q_r;
  assign clr_ch = clr_r[5:0];
  assign clr_ok = ({1'b0, clr_ch} < 7'(VOICE_COUNT));

  always_comb begin
    res_nxt = '0;
    res_nxt.active_voices = acnt_nxt;
    case (cur_r.func)
      FN_ADDR_RD: res_nxt.read_data = 16'(addr_r);
      FN_DATA_RD: res_nxt.read_data = rf_q_r;
      FN_KEY_STAT: res_nxt.read_data = {15'd0, kc_r != '0};
      FN_KEY_DATA: if (kc_r != '0) res_nxt.read_data = kq_q_r;
      FN_INJECT: res_nxt.key_overflow = !(kc_r < (KW+1)'(KEY_QUEUE_DEPTH));
      FN_QUERY: if (qch < 7'(VOICE_COUNT)) begin
        res_nxt.voice_note      = note_q_r;
        res_nxt.voice_velocity  = vel_q_r;
        res_nxt.voice_sounding  = snd_r[qch[5:0]];
        res_nxt.voice_releasing = rel_r[qch[5:0]];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CLR) rf_mem[clr_r] <= '0;
    else if (exec && cur_r.func == FN_DATA_WR) rf_mem[addr_r[RW-1:0]] <= d;
    if (exec && cur_r.func == FN_INJECT && kc_r < (KW+1)'(KEY_QUEUE_DEPTH))
      kq_mem[kh_r] <= d;
    if (exec && cur_r.func == FN_KEY_DATA && kc_r != '0 && kq_q_r[7])
      pq_mem[ph_r] <= {kq_q_r[15:8], pend_note};
  end

  // voice stores are zeroed during the register-file clearing pass
  always_ff @(posedge clk) begin
    if (st_r == ST_CLR) begin
      if (clr_ok) begin
        pitch_r[clr_ch] <= '0; note_r[clr_ch] <= '0; vel_r[clr_ch] <= '0;
      end
    end else if (exec && cur_r.func == FN_DATA_WR && vsel) begin
      if (addr_r[11:8] == 4'd1) pitch_r[ch] <= d;
      else if (grp0_wr && d == CTL_KEY_ON) begin
        if (pc_r != '0) begin
          note_r[ch] <= pend_w[7:0]; vel_r[ch] <= pend_w[15:8];
        end else if (pitch_q_r != '0) begin
          note_r[ch] <= pn; vel_r[ch] <= DEFAULT_VEL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_item;
    out_strobe <= rst_n && exec;
    if (!rst_n) begin
      st_r <= ST_CLR; clr_r <= '0; addr_r <= '0; acnt_r <= '0;
      act_r <= '0; snd_r <= '0; rel_r <= '0;
      ph_r <= '0; pt_r <= '0; pc_r <= '0; kh_r <= '0; kt_r <= '0; kc_r <= '0;
    end else begin
      unique case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == RW'(REG_WORDS - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: if (pop) st_r <= ST_EXEC;
        ST_EXEC: begin
          st_r <= ST_IDLE;
          out_item <= res_nxt;
          acnt_r <= acnt_nxt;
          case (cur_r.func)
            FN_ADDR_WR: addr_r <= d[ADDR_W-1:0];
            FN_KEY_DATA: if (kc_r != '0) begin
              kt_r <= (kt_r == KW'(KEY_QUEUE_DEPTH-1)) ? '0 : kt_r + 1'b1;
              kc_r <= kc_r - 1'b1;
              if (kq_q_r[7]) begin
                ph_r <= (ph_r == PW'(PENDING_DEPTH-1)) ? '0 : ph_r + 1'b1;
                if (pc_r == (PW+1)'(PENDING_DEPTH))
                  pt_r <= (pt_r == PW'(PENDING_DEPTH-1)) ? '0 : pt_r + 1'b1;
                else pc_r <= pc_r + 1'b1;
              end
            end
            FN_INJECT: if (kc_r < (KW+1)'(KEY_QUEUE_DEPTH)) begin
              kh_r <= (kh_r == KW'(KEY_QUEUE_DEPTH-1)) ? '0 : kh_r + 1'b1;
              kc_r <= kc_r + 1'b1;
            end
            FN_DATA_WR: if (grp0_wr) begin
              if (d == CTL_KEY_ON) begin
                act_r[ch] <= 1'b1;
                if (pc_r != '0) begin
                  pt_r <= (pt_r == PW'(PENDING_DEPTH-1)) ? '0 : pt_r + 1'b1;
                  pc_r <= pc_r - 1'b1;
                  snd_r[ch] <= 1'b1; rel_r[ch] <= 1'b0;
                end else if (pitch_q_r != '0) begin
                  snd_r[ch] <= 1'b1; rel_r[ch] <= 1'b0;
                end
              end else if (d == CTL_KEY_OFF || d == CTL_RELEASE || d == CTL_OFF) begin
                act_r[ch] <= 1'b0;
                rel_r[ch] <= (d != CTL_OFF);
                if (d == CTL_OFF) snd_r[ch] <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/tone_generator_voice_register_tracker.sv =====
// Register-mapped voice tracker for a tone generator.
// Input: pulse start with in_item (func, bus_data) while busy is low; the
// item is accepted on that edge. Items land in a two-entry queue, and an
// execute unit takes one item at a time (queue read, then memory
// read-modify-write); it takes no new item until the last is done. From
// accept to out_strobe an item passes the queue, cur_r and out_strobe.
// Output: out_strobe is high for one cycle with out_item valid; there is
// no backpressure, every result must be taken in that cycle.
// Reset (rst_n low, synchronous) clears voice flags and queues, then the
// 4096-word register file and the per-voice pitch, note and velocity
// stores are cleared one word per cycle; during this pass items are
// queued (up to two) but not executed.
// busy rises when the queue holds two items.
module tone_generator_voice_register_tracker
  import tgvrt_pkg::*;
#(
  parameter int VOICE_COUNT     = 64,
  parameter int PENDING_DEPTH   = 16,
  parameter int KEY_QUEUE_DEPTH = 16,
  parameter int REG_WORDS       = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);
  logic     pop, q_valid;
  in_item_t q_item;

  tgvrt_front u_front (
    .clk, .rst_n, .start, .in_item, .pop, .busy, .q_valid, .q_item
  );

  tgvrt_back #(
    .VOICE_COUNT(VOICE_COUNT), .PENDING_DEPTH(PENDING_DEPTH),
    .KEY_QUEUE_DEPTH(KEY_QUEUE_DEPTH), .REG_WORDS(REG_WORDS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_item, .pop, .out_strobe, .out_item
  );

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.active_voices <= 7'(VOICE_COUNT))
    else $error("active count out of range");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results too close");
endmodule
